// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the authentication kernel.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AM_ASSERT_IMP(lbl, ante, cons)
`define AM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/c128_pkg.sv =====
// Types, substitution tables and lookup function of the COMP128-1 kernel.
// No dependencies.
package c128_pkg;

    localparam int NumBytes  = 32;
    localparam int NumLevels = 5;
    localparam int NumRounds = 8;
    localparam int NumCells  = NumLevels * NumRounds;

    typedef logic [NumBytes-1:0][7:0] t_state;
    typedef logic [15:0][7:0]         t_key;

    typedef struct packed {
        logic [2:0] level;
        logic       load_key;
        logic       permute;
    } t_cell_ctrl;

    localparam logic [2:0] LevelLast = 3'd4;

    localparam logic [7:0] Sbox0 [512] = '{
        8'h66, 8'hB1, 8'hBA, 8'hA2, 8'h02, 8'h9C, 8'h70, 8'h4B, 8'h37, 8'h19, 8'h08, 8'h0C,
        8'hFB, 8'hC1, 8'hF6, 8'hBC, 8'h6D, 8'hD5, 8'h97, 8'h35, 8'h2A, 8'h4F, 8'hBF, 8'h73,
        8'hE9, 8'hF2, 8'hA4, 8'hDF, 8'hD1, 8'h94, 8'h6C, 8'hA1, 8'hFC, 8'h25, 8'hF4, 8'h2F,
        8'h40, 8'hD3, 8'h06, 8'hED, 8'hB9, 8'hA0, 8'h8B, 8'h71, 8'h4C, 8'h8A, 8'h3B, 8'h46,
        8'h43, 8'h1A, 8'h0D, 8'h9D, 8'h3F, 8'hB3, 8'hDD, 8'h1E, 8'hD6, 8'h24, 8'hA6, 8'h45,
        8'h98, 8'h7C, 8'hCF, 8'h74, 8'hF7, 8'hC2, 8'h29, 8'h54, 8'h47, 8'h01, 8'h31, 8'h0E,
        8'h5F, 8'h23, 8'hA9, 8'h15, 8'h60, 8'h4E, 8'hD7, 8'hE1, 8'hB6, 8'hF3, 8'h1C, 8'h5C,
        8'hC9, 8'h76, 8'h04, 8'h4A, 8'hF8, 8'h80, 8'h11, 8'h0B, 8'h92, 8'h84, 8'hF5, 8'h30,
        8'h95, 8'h5A, 8'h78, 8'h27, 8'h57, 8'hE6, 8'h6A, 8'hE8, 8'hAF, 8'h13, 8'h7E, 8'hBE,
        8'hCA, 8'h8D, 8'h89, 8'hB0, 8'hFA, 8'h1B, 8'h65, 8'h28, 8'hDB, 8'hE3, 8'h3A, 8'h14,
        8'h33, 8'hB2, 8'h62, 8'hD8, 8'h8C, 8'h16, 8'h20, 8'h79, 8'h3D, 8'h67, 8'hCB, 8'h48,
        8'h1D, 8'h6E, 8'h55, 8'hD4, 8'hB4, 8'hCC, 8'h96, 8'hB7, 8'h0F, 8'h42, 8'hAC, 8'hC4,
        8'h38, 8'hC5, 8'h9E, 8'h00, 8'h64, 8'h2D, 8'h99, 8'h07, 8'h90, 8'hDE, 8'hA3, 8'hA7,
        8'h3C, 8'h87, 8'hD2, 8'hE7, 8'hAE, 8'hA5, 8'h26, 8'hF9, 8'hE0, 8'h22, 8'hDC, 8'hE5,
        8'hD9, 8'hD0, 8'hF1, 8'h44, 8'hCE, 8'hBD, 8'h7D, 8'hFF, 8'hEF, 8'h36, 8'hA8, 8'h59,
        8'h7B, 8'h7A, 8'h49, 8'h91, 8'h75, 8'hEA, 8'h8F, 8'h63, 8'h81, 8'hC8, 8'hC0, 8'h52,
        8'h68, 8'hAA, 8'h88, 8'hEB, 8'h5D, 8'h51, 8'hCD, 8'hAD, 8'hEC, 8'h5E, 8'h69, 8'h34,
        8'h2E, 8'hE4, 8'hC6, 8'h05, 8'h39, 8'hFE, 8'h61, 8'h9B, 8'h8E, 8'h85, 8'hC7, 8'hAB,
        8'hBB, 8'h32, 8'h41, 8'hB5, 8'h7F, 8'h6B, 8'h93, 8'hE2, 8'hB8, 8'hDA, 8'h83, 8'h21,
        8'h4D, 8'h56, 8'h1F, 8'h2C, 8'h58, 8'h3E, 8'hEE, 8'h12, 8'h18, 8'h2B, 8'h9A, 8'h17,
        8'h50, 8'h9F, 8'h86, 8'h6F, 8'h09, 8'h72, 8'h03, 8'h5B, 8'h10, 8'h82, 8'h53, 8'h0A,
        8'hC3, 8'hF0, 8'hFD, 8'h77, 8'hB1, 8'h66, 8'hA2, 8'hBA, 8'h9C, 8'h02, 8'h4B, 8'h70,
        8'h19, 8'h37, 8'h0C, 8'h08, 8'hC1, 8'hFB, 8'hBC, 8'hF6, 8'hD5, 8'h6D, 8'h35, 8'h97,
        8'h4F, 8'h2A, 8'h73, 8'hBF, 8'hF2, 8'hE9, 8'hDF, 8'hA4, 8'h94, 8'hD1, 8'hA1, 8'h6C,
        8'h25, 8'hFC, 8'h2F, 8'hF4, 8'hD3, 8'h40, 8'hED, 8'h06, 8'hA0, 8'hB9, 8'h71, 8'h8B,
        8'h8A, 8'h4C, 8'h46, 8'h3B, 8'h1A, 8'h43, 8'h9D, 8'h0D, 8'hB3, 8'h3F, 8'h1E, 8'hDD,
        8'h24, 8'hD6, 8'h45, 8'hA6, 8'h7C, 8'h98, 8'h74, 8'hCF, 8'hC2, 8'hF7, 8'h54, 8'h29,
        8'h01, 8'h47, 8'h0E, 8'h31, 8'h23, 8'h5F, 8'h15, 8'hA9, 8'h4E, 8'h60, 8'hE1, 8'hD7,
        8'hF3, 8'hB6, 8'h5C, 8'h1C, 8'h76, 8'hC9, 8'h4A, 8'h04, 8'h80, 8'hF8, 8'h0B, 8'h11,
        8'h84, 8'h92, 8'h30, 8'hF5, 8'h5A, 8'h95, 8'h27, 8'h78, 8'hE6, 8'h57, 8'hE8, 8'h6A,
        8'h13, 8'hAF, 8'hBE, 8'h7E, 8'h8D, 8'hCA, 8'hB0, 8'h89, 8'h1B, 8'hFA, 8'h28, 8'h65,
        8'hE3, 8'hDB, 8'h14, 8'h3A, 8'hB2, 8'h33, 8'hD8, 8'h62, 8'h16, 8'h8C, 8'h79, 8'h20,
        8'h67, 8'h3D, 8'h48, 8'hCB, 8'h6E, 8'h1D, 8'hD4, 8'h55, 8'hCC, 8'hB4, 8'hB7, 8'h96,
        8'h42, 8'h0F, 8'hC4, 8'hAC, 8'hC5, 8'h38, 8'h00, 8'h9E, 8'h2D, 8'h64, 8'h07, 8'h99,
        8'hDE, 8'h90, 8'hA7, 8'hA3, 8'h87, 8'h3C, 8'hE7, 8'hD2, 8'hA5, 8'hAE, 8'hF9, 8'h26,
        8'h22, 8'hE0, 8'hE5, 8'hDC, 8'hD0, 8'hD9, 8'h44, 8'hF1, 8'hBD, 8'hCE, 8'hFF, 8'h7D,
        8'h36, 8'hEF, 8'h59, 8'hA8, 8'h7A, 8'h7B, 8'h91, 8'h49, 8'hEA, 8'h75, 8'h63, 8'h8F,
        8'hC8, 8'h81, 8'h52, 8'hC0, 8'hAA, 8'h68, 8'hEB, 8'h88, 8'h51, 8'h5D, 8'hAD, 8'hCD,
        8'h5E, 8'hEC, 8'h34, 8'h69, 8'hE4, 8'h2E, 8'h05, 8'hC6, 8'hFE, 8'h39, 8'h9B, 8'h61,
        8'h85, 8'h8E, 8'hAB, 8'hC7, 8'h32, 8'hBB, 8'hB5, 8'h41, 8'h6B, 8'h7F, 8'hE2, 8'h93,
        8'hDA, 8'hB8, 8'h21, 8'h83, 8'h56, 8'h4D, 8'h2C, 8'h1F, 8'h3E, 8'h58, 8'h12, 8'hEE,
        8'h2B, 8'h18, 8'h17, 8'h9A, 8'h9F, 8'h50, 8'h6F, 8'h86, 8'h72, 8'h09, 8'h5B, 8'h03,
        8'h82, 8'h10, 8'h0A, 8'h53, 8'hF0, 8'hC3, 8'h77, 8'hFD
    };

    localparam logic [7:0] Sbox1 [256] = '{
        8'h13, 8'h0B, 8'h50, 8'h72, 8'h2B, 8'h01, 8'h45, 8'h5E, 8'h27, 8'h12, 8'h7F, 8'h75,
        8'h61, 8'h03, 8'h55, 8'h2B, 8'h1B, 8'h7C, 8'h46, 8'h53, 8'h2F, 8'h47, 8'h3F, 8'h0A,
        8'h2F, 8'h59, 8'h4F, 8'h04, 8'h0E, 8'h3B, 8'h0B, 8'h05, 8'h23, 8'h6B, 8'h67, 8'h44,
        8'h15, 8'h56, 8'h24, 8'h5B, 8'h55, 8'h7E, 8'h20, 8'h32, 8'h6D, 8'h5E, 8'h78, 8'h06,
        8'h35, 8'h4F, 8'h1C, 8'h2D, 8'h63, 8'h5F, 8'h29, 8'h22, 8'h58, 8'h44, 8'h5D, 8'h37,
        8'h6E, 8'h7D, 8'h69, 8'h14, 8'h5A, 8'h50, 8'h4C, 8'h60, 8'h17, 8'h3C, 8'h59, 8'h40,
        8'h79, 8'h38, 8'h0E, 8'h4A, 8'h65, 8'h08, 8'h13, 8'h4E, 8'h4C, 8'h42, 8'h68, 8'h2E,
        8'h6F, 8'h32, 8'h20, 8'h03, 8'h27, 8'h00, 8'h3A, 8'h19, 8'h5C, 8'h16, 8'h12, 8'h33,
        8'h39, 8'h41, 8'h77, 8'h74, 8'h16, 8'h6D, 8'h07, 8'h56, 8'h3B, 8'h5D, 8'h3E, 8'h6E,
        8'h4E, 8'h63, 8'h4D, 8'h43, 8'h0C, 8'h71, 8'h57, 8'h62, 8'h66, 8'h05, 8'h58, 8'h21,
        8'h26, 8'h38, 8'h17, 8'h08, 8'h4B, 8'h2D, 8'h0D, 8'h4B, 8'h5F, 8'h3F, 8'h1C, 8'h31,
        8'h7B, 8'h78, 8'h14, 8'h70, 8'h2C, 8'h1E, 8'h0F, 8'h62, 8'h6A, 8'h02, 8'h67, 8'h1D,
        8'h52, 8'h6B, 8'h2A, 8'h7C, 8'h18, 8'h1E, 8'h29, 8'h10, 8'h6C, 8'h64, 8'h75, 8'h28,
        8'h49, 8'h28, 8'h07, 8'h72, 8'h52, 8'h73, 8'h24, 8'h70, 8'h0C, 8'h66, 8'h64, 8'h54,
        8'h5C, 8'h30, 8'h48, 8'h61, 8'h09, 8'h36, 8'h37, 8'h4A, 8'h71, 8'h7B, 8'h11, 8'h1A,
        8'h35, 8'h3A, 8'h04, 8'h09, 8'h45, 8'h7A, 8'h15, 8'h76, 8'h2A, 8'h3C, 8'h1B, 8'h49,
        8'h76, 8'h7D, 8'h22, 8'h0F, 8'h41, 8'h73, 8'h54, 8'h40, 8'h3E, 8'h51, 8'h46, 8'h01,
        8'h18, 8'h6F, 8'h79, 8'h53, 8'h68, 8'h51, 8'h31, 8'h7F, 8'h30, 8'h69, 8'h1F, 8'h0A,
        8'h06, 8'h5B, 8'h57, 8'h25, 8'h10, 8'h36, 8'h74, 8'h7E, 8'h1F, 8'h26, 8'h0D, 8'h00,
        8'h48, 8'h6A, 8'h4D, 8'h3D, 8'h1A, 8'h43, 8'h2E, 8'h1D, 8'h60, 8'h25, 8'h3D, 8'h34,
        8'h65, 8'h11, 8'h2C, 8'h6C, 8'h47, 8'h34, 8'h42, 8'h39, 8'h21, 8'h33, 8'h19, 8'h5A,
        8'h02, 8'h77, 8'h7A, 8'h23
    };

    localparam logic [7:0] Sbox2 [128] = '{
        8'h34, 8'h32, 8'h2C, 8'h06, 8'h15, 8'h31, 8'h29, 8'h3B, 8'h27, 8'h33, 8'h19, 8'h20,
        8'h33, 8'h2F, 8'h34, 8'h2B, 8'h25, 8'h04, 8'h28, 8'h22, 8'h3D, 8'h0C, 8'h1C, 8'h04,
        8'h3A, 8'h17, 8'h08, 8'h0F, 8'h0C, 8'h16, 8'h09, 8'h12, 8'h37, 8'h0A, 8'h21, 8'h23,
        8'h32, 8'h01, 8'h2B, 8'h03, 8'h39, 8'h0D, 8'h3E, 8'h0E, 8'h07, 8'h2A, 8'h2C, 8'h3B,
        8'h3E, 8'h39, 8'h1B, 8'h06, 8'h08, 8'h1F, 8'h1A, 8'h36, 8'h29, 8'h16, 8'h2D, 8'h14,
        8'h27, 8'h03, 8'h10, 8'h38, 8'h30, 8'h02, 8'h15, 8'h1C, 8'h24, 8'h2A, 8'h3C, 8'h21,
        8'h22, 8'h12, 8'h00, 8'h0B, 8'h18, 8'h0A, 8'h11, 8'h3D, 8'h1D, 8'h0E, 8'h2D, 8'h1A,
        8'h37, 8'h2E, 8'h0B, 8'h11, 8'h36, 8'h2E, 8'h09, 8'h18, 8'h1E, 8'h3C, 8'h20, 8'h00,
        8'h14, 8'h26, 8'h02, 8'h1E, 8'h3A, 8'h23, 8'h01, 8'h10, 8'h38, 8'h28, 8'h17, 8'h30,
        8'h0D, 8'h13, 8'h13, 8'h1B, 8'h1F, 8'h35, 8'h2F, 8'h26, 8'h3F, 8'h0F, 8'h31, 8'h05,
        8'h25, 8'h35, 8'h19, 8'h24, 8'h3F, 8'h1D, 8'h05, 8'h07
    };

    localparam logic [7:0] Sbox3 [64] = '{
        8'h01, 8'h05, 8'h1D, 8'h06, 8'h19, 8'h01, 8'h12, 8'h17, 8'h11, 8'h13, 8'h00,
        8'h09, 8'h18, 8'h19, 8'h06, 8'h1F, 8'h1C, 8'h14, 8'h18, 8'h1E, 8'h04, 8'h1B,
        8'h03, 8'h0D, 8'h0F, 8'h10, 8'h0E, 8'h12, 8'h04, 8'h03, 8'h08, 8'h09, 8'h14,
        8'h00, 8'h0C, 8'h1A, 8'h15, 8'h08, 8'h1C, 8'h02, 8'h1D, 8'h02, 8'h0F, 8'h07,
        8'h0B, 8'h16, 8'h0E, 8'h0A, 8'h11, 8'h15, 8'h0C, 8'h1E, 8'h1A, 8'h1B, 8'h10,
        8'h1F, 8'h0B, 8'h07, 8'h0D, 8'h17, 8'h0A, 8'h05, 8'h16, 8'h13
    };

    localparam logic [7:0] Sbox4 [32] = '{
        8'h0F, 8'h0C, 8'h0A, 8'h04, 8'h01, 8'h0E, 8'h0B, 8'h07, 8'h05, 8'h00, 8'h0E,
        8'h07, 8'h01, 8'h02, 8'h0D, 8'h08, 8'h0A, 8'h03, 8'h04, 8'h09, 8'h06, 8'h00,
        8'h03, 8'h02, 8'h05, 8'h06, 8'h08, 8'h09, 8'h0B, 8'h0D, 8'h0F, 8'h0C
    };

    function automatic logic [7:0] sbox_lookup(input logic [2:0] level, input logic [9:0] idx);
        logic [7:0] res;
        case (level)
            3'd0: res = Sbox0[idx[8:0]];
            3'd1: res = Sbox1[idx[7:0]];
            3'd2: res = Sbox2[idx[6:0]];
            3'd3: res = Sbox3[idx[5:0]];
            3'd4: res = Sbox4[idx[4:0]];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/c128_cell.sv =====
// One butterfly level of one round: key reload, table substitution, bit permutation.
// Depends on c128_pkg and assert_macros.svh.
`include "assert_macros.svh"
module c128_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c128_pkg::t_cell_ctrl i_ctrl,
    input  c128_pkg::t_key       i_key,
    input  logic                 i_valid,
    input  c128_pkg::t_state     i_w,
    output logic                 o_ready,
    output logic                 o_valid,
    output c128_pkg::t_state     o_w,
    input  logic                 i_ready_next
);

    logic             r_valid;
    c128_pkg::t_state r_w;
    c128_pkg::t_state n_w;
    c128_pkg::t_state src;
    c128_pkg::t_state sub;
    logic [4:0]       half;
    logic [127:0]     nib;
    logic [127:0]     perm;
    logic             high_nib_set;

    always_comb begin
        src = i_w;
        if (i_ctrl.load_key) begin
            for (int i = 0; i < 16; i++) begin
                src[i] = i_key[i];
            end
        end
        half = 5'd16 >> i_ctrl.level;
        for (int i = 0; i < c128_pkg::NumBytes; i++) begin
            sub[i] = c128_pkg::sbox_lookup(i_ctrl.level,
                10'(src[i]) + {1'b0, src[5'(i) ^ half], 1'b0});
        end
        for (int j = 0; j < c128_pkg::NumBytes; j++) begin
            for (int k = 0; k < 4; k++) begin
                nib[127 - (4 * j + k)] = sub[j][3 - k];
            end
        end
        for (int i = 0; i < 128; i++) begin
            perm[127 - i] = nib[127 - int'(7'(i * 17))];
        end
        n_w = sub;
        if (i_ctrl.permute) begin
            for (int j = 0; j < 16; j++) begin
                n_w[16 + j] = perm[127 - 8 * j -: 8];
            end
        end
    end

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;
    assign o_w     = r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_w <= n_w;
        end
    end

    always_comb begin
        high_nib_set = 1'b0;
        for (int i = 0; i < c128_pkg::NumBytes; i++) begin
            high_nib_set = high_nib_set | (|r_w[i][7:4]);
        end
    end

    `AM_ASSERT_NEXT(a_hold_valid, r_valid && !i_ready_next, r_valid)
    `AM_ASSERT_NEXT(a_hold_word, r_valid && !i_ready_next, $stable(r_w))
    `AM_ASSERT_IMP(a_last_nibbles,
        r_valid && (i_ctrl.level == c128_pkg::LevelLast) && !i_ctrl.permute, !high_nib_set)

endmodule

// ===== hw/rtl/comp128_auth_kernel.sv =====
// Top level of the COMP128-1 authentication kernel: key registers, cell chain, result packing.
// Depends on c128_pkg and c128_cell.
//
// Usage:
//   Write the subscriber key through the APB port: key_high at byte address 0,
//   key_low at byte address 8, 64-bit data. Reads return the stored key.
//   Present a challenge word on i_challenge_high/i_challenge_low with i_valid;
//   it is taken when o_ready is high. The result word appears on
//   o_signed_response/o_cipher_key with o_valid and is taken with i_ready.
//   The word passes through a chain of 40 cells, one per butterfly level of
//   each of the eight rounds, each with its own register. Throughput is one
//   challenge per cycle while the receiver holds i_ready high.
//   When the receiver stalls, words pile up in the chain; empty cells keep
//   accepting, so o_ready falls only once all 40 cells hold a word.
//   Reset empties the chain and clears both key registers to zero.
module comp128_auth_kernel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_challenge_high,
    input  logic [63:0] i_challenge_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_signed_response,
    output logic [63:0] o_cipher_key
);

    logic [63:0]      r_key_high;
    logic [63:0]      r_key_low;
    c128_pkg::t_key   key;
    c128_pkg::t_state chain_w  [c128_pkg::NumCells + 1];
    logic             chain_v  [c128_pkg::NumCells + 1];
    logic             chain_rd [c128_pkg::NumCells + 1];
    c128_pkg::t_state res;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = paddr[3] ? r_key_low : r_key_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (wr_en) begin
            if (paddr[3]) begin
                r_key_low <= pwdata;
            end else begin
                r_key_high <= pwdata;
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            key[b]     = r_key_high[63 - 8 * b -: 8];
            key[b + 8] = r_key_low[63 - 8 * b -: 8];
        end
        chain_w[0] = '0;
        for (int b = 0; b < 8; b++) begin
            chain_w[0][16 + b] = i_challenge_high[63 - 8 * b -: 8];
            chain_w[0][24 + b] = i_challenge_low[63 - 8 * b -: 8];
        end
    end

    assign chain_v[0]                      = i_valid;
    assign o_ready                         = chain_rd[0];
    assign chain_rd[c128_pkg::NumCells]    = i_ready;

    for (genvar s = 0; s < c128_pkg::NumCells; s++) begin : g_cell
        localparam int Lvl = s % c128_pkg::NumLevels;
        c128_pkg::t_cell_ctrl ctrl;
        assign ctrl.level    = 3'(Lvl);
        assign ctrl.load_key = (Lvl == 0);
        assign ctrl.permute  = (Lvl == c128_pkg::NumLevels - 1) &&
                               (s < c128_pkg::NumCells - 1);
        c128_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_key        (key),
            .i_valid      (chain_v[s]),
            .i_w          (chain_w[s]),
            .o_ready      (chain_rd[s]),
            .o_valid      (chain_v[s + 1]),
            .o_w          (chain_w[s + 1]),
            .i_ready_next (chain_rd[s + 1])
        );
    end

    assign res     = chain_w[c128_pkg::NumCells];
    assign o_valid = chain_v[c128_pkg::NumCells];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            o_signed_response[31 - 8 * j -: 8] = {res[2 * j][3:0], res[2 * j + 1][3:0]};
        end
        for (int j = 0; j < 6; j++) begin
            o_cipher_key[63 - 8 * j -: 8] =
                {res[2 * j + 18][1:0], res[2 * j + 19][3:0], res[2 * j + 20][3:2]};
        end
        o_cipher_key[15:8] = {res[30][1:0], res[31][3:0], 2'b00};
        o_cipher_key[7:0]  = 8'h00;
    end

endmodule
